FILE: sv/color_key_span_extractor_unit_assert.svh
// Assertion macros shared by the color key span extractor RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef COLOR_KEY_SPAN_EXTRACTOR_UNIT_ASSERT_SVH
`define COLOR_KEY_SPAN_EXTRACTOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge out of reset
`define CKSE_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be true at a clock edge out of reset
`define CKSE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CKSE_ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define CKSE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: sv/ckse_pkg.sv
// Shared types, codes and key helpers of the color key span extractor.
// No dependencies; imported by the span tracker and the top level.
package ckse_pkg;

	// Pixel formats, as written to the format register
	typedef enum logic [1:0] {
		FMT_PALETTE = 2'd0,
		FMT_RGB565  = 2'd1,
		FMT_RGB24   = 2'd2,
		FMT_RAW32   = 2'd3
	} pix_fmt_t;

	// Input beat kinds (carried in tuser)
	localparam logic CMD_PIXEL     = 1'b0;
	localparam logic CMD_PAL_WRITE = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_KEY_COLOR    = 2'd0;
	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
	localparam logic [1:0] REG_LINE_WIDTH   = 2'd2;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

	// Palette geometry
	localparam int PAL_DEPTH = 256;
	localparam int PAL_WIDTH = 32;

	// Channel and field widths
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_DATA_W  = 24;
	localparam int DIM_W       = 13;

	// Pixel handed from the compare stage to the span tracker
	typedef struct packed {
		logic step;
		logic opaque;
	} pix_ctl_t;

	// Span produced for the current pixel
	typedef struct packed {
		logic        emit;
		logic [11:0] start_col;
		logic [12:0] end_col;
		logic [11:0] row;
	} span_t;

	// 0x00BBGGRR color reference to 0x00RRGGBB
	function automatic logic [23:0] key_to_rgb(input logic [23:0] key);
		return {key[7:0], key[15:8], key[23:16]};
	endfunction

	// Key reduced to RGB565 (R in the top bits)
	function automatic logic [15:0] key_to_565(input logic [23:0] key);
		return {key[7:3], key[15:10], key[23:19]};
	endfunction

endpackage

FILE: sv/ckse_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies; holds the palette of the color key span extractor.
module ckse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/ckse_span_tracker.sv
// Column/row counters and opaque run bookkeeping of the span extractor.
// Depends on ckse_pkg and the assertion macro header.
`include "color_key_span_extractor_unit_assert.svh"

module ckse_span_tracker import ckse_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pix_ctl_t      ctl,
	input  logic [WW-1:0] width,
	input  logic [HW-1:0] height,
	output span_t         span
);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          run_open_q;
	logic [CW-1:0] run_begin_q;

	logic [WW-1:0] col_inc;
	logic [HW-1:0] row_inc;
	logic          last;
	logic          row_wrap;
	logic          open_n;
	logic [CW-1:0] begin_n;
	logic          emit;
	logic [CW-1:0] s_col;
	logic [WW-1:0] e_col;
	logic [31:0]   s_ext;
	logic [31:0]   e_ext;
	logic [31:0]   r_ext;

	// End of line and end of frame
	assign col_inc  = WW'(col_q) + WW'(1);
	assign last     = (col_inc >= width);
	assign row_inc  = HW'(row_q) + HW'(1);
	assign row_wrap = (row_inc >= height);

	// Run open/close for this pixel; the line end closes any open run
	always_comb begin
		open_n  = run_open_q;
		begin_n = run_begin_q;
		emit    = 1'b0;
		s_col   = run_begin_q;
		e_col   = WW'(col_q);
		if (run_open_q) begin
			if (!ctl.opaque) begin
				emit   = 1'b1;
				open_n = 1'b0;
			end
		end else if (ctl.opaque) begin
			begin_n = col_q;
			open_n  = 1'b1;
		end
		if (last && open_n) begin
			emit   = 1'b1;
			s_col  = begin_n;
			e_col  = width;
			open_n = 1'b0;
		end
	end

	// Span fields at their output widths
	assign s_ext = 32'(s_col);
	assign e_ext = 32'(e_col);
	assign r_ext = 32'(row_q);

	always_comb begin
		span.emit      = ctl.step && emit;
		span.start_col = s_ext[11:0];
		span.end_col   = e_ext[12:0];
		span.row       = r_ext[11:0];
	end

	// State advances once per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			run_open_q  <= 1'b0;
			run_begin_q <= '0;
		end else if (ctl.step) begin
			run_open_q  <= open_n;
			run_begin_q <= begin_n;
			if (last) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : RW'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	`CKSE_ASSERT_PROP(a_eol_closes_run, clk, arst_n, ctl.step && last |=> !run_open_q, "run open after line end")
	`CKSE_ASSERT_PROP(a_eol_col_zero, clk, arst_n, ctl.step && last |=> col_q == '0, "column not reset at line end")
	`CKSE_ASSERT_PROP(a_emit_closes_run, clk, arst_n, span.emit |=> !run_open_q, "run still open after its span")

endmodule

FILE: sv/color_key_span_extractor_unit.sv
// Top level of the color key span extractor: config, palette, compare, output register.
// Depends on ckse_pkg, ckse_ram, ckse_span_tracker and the assertion macro header.
//
// Usage:
//   Input stream s_*: one beat per pixel or palette write. s_tuser[0] is the
//   command (pixel or palette write); s_tdata carries the pixel or color bits
//   and the palette index. Pixels arrive top row first, left to right.
//   Output stream m_*: one beat per finished opaque run (start, end, row).
//   Configuration: cfg_we/cfg_index/cfg_data write key, format, width, height;
//   write only while the block is idle.
//   Pipeline: a pixel is registered with its palette read in the input stage,
//   then compared and tracked, and its span is registered in the output register.
//   Throughput: one beat per cycle unless m_tready stalls, set by the single compare
//   stage and registered palette read; palette writes take the write port directly.
//   Stall: while m_tready is low the span stays in the output register, one
//   more pixel may be held in the input stage, then s_tready drops.
//   Reset: counters, run state and valids clear; key 0, 32-bit format,
//   width 1 and height 1. Palette contents are undefined until written.
`include "color_key_span_extractor_unit_assert.svh"

module color_key_span_extractor_unit import ckse_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input beats
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value, [39:32] palette write index
	input  logic [0:0]             s_tuser,   // [0] command
	// Span beats
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] span_start, [24:12] span_end,
	                                          // [36:25] span_row, [39:37] zero
	// Configuration writes
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [23:0]          key_rgb_q;
	logic [15:0]          key565_q;
	pix_fmt_t             fmt_q;
	logic [WW-1:0]        width_q;
	logic [HW-1:0]        height_q;

	logic                 accept;
	logic                 adv;
	logic                 valid_s1;
	logic [31:0]          value_s1;
	logic [PAL_WIDTH-1:0] pal_rdata;
	logic                 opaque;
	pix_ctl_t             ctl;
	span_t                span;

	logic                 out_valid_q;
	logic [11:0]          out_start_q;
	logic [12:0]          out_end_q;
	logic [11:0]          out_row_q;

	logic [DIM_W-1:0]     cfg_dim;
	logic [WW-1:0]        width_clamped;
	logic [HW-1:0]        height_clamped;

	// Dimensions: zero reads as one, large values saturate
	assign cfg_dim = cfg_data[DIM_W-1:0];
	always_comb begin
		if (cfg_dim == '0) begin
			width_clamped  = WW'(1);
			height_clamped = HW'(1);
		end else begin
			width_clamped  = (32'(cfg_dim) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_dim);
			height_clamped = (32'(cfg_dim) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_dim);
		end
	end

	// Configuration registers, key kept pre-swapped in both compare forms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_rgb_q <= '0;
			key565_q  <= '0;
			fmt_q     <= FMT_RAW32;
			width_q   <= WW'(1);
			height_q  <= HW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_COLOR: begin
					key_rgb_q <= key_to_rgb(cfg_data);
					key565_q  <= key_to_565(cfg_data);
				end
				REG_PIXEL_FORMAT: fmt_q    <= pix_fmt_t'(cfg_data[1:0]);
				REG_LINE_WIDTH:   width_q  <= width_clamped;
				REG_IMAGE_HEIGHT: height_q <= height_clamped;
				default: ;
			endcase
		end
	end

	// Handshake: the stage moves when the output register is free or drained
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	// Input stage; palette writes go straight to the RAM and skip it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && (s_tuser[0] == CMD_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= s_tdata[31:0];
		end
	end

	ckse_ram #(
		.WIDTH (PAL_WIDTH),
		.DEPTH (PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (accept && (s_tuser[0] == CMD_PAL_WRITE)),
		.waddr (s_tdata[39:32]),
		.wdata (s_tdata[31:0]),
		.re    (accept && (s_tuser[0] == CMD_PIXEL)),
		.raddr (s_tdata[7:0]),
		.rdata (pal_rdata)
	);

	// Key compare per format
	always_comb begin
		unique case (fmt_q)
			FMT_PALETTE: opaque = (pal_rdata != {8'h00, key_rgb_q});
			FMT_RGB565:  opaque = (value_s1[15:0] != key565_q);
			FMT_RGB24:   opaque = (value_s1[23:0] != key_rgb_q);
			FMT_RAW32:   opaque = (value_s1 != {8'h00, key_rgb_q});
			default:     opaque = 1'b1;
		endcase
	end

	assign ctl.step   = valid_s1 && adv;
	assign ctl.opaque = opaque;

	ckse_span_tracker #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.width  (width_q),
		.height (height_q),
		.span   (span)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= span.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && span.emit) begin
			out_start_q <= span.start_col;
			out_end_q   <= span.end_col;
			out_row_q   <= span.row;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_row_q, out_end_q, out_start_q};

	`CKSE_ASSERT_PROP(a_no_span_without_pixel, clk, arst_n, adv && !valid_s1 |=> !out_valid_q, "span without a pixel")
	`CKSE_ASSERT_PROP(a_pal_write_skips_stage, clk, arst_n, accept && (s_tuser[0] == CMD_PAL_WRITE) |=> !valid_s1, "palette write entered the pixel stage")
	`CKSE_ASSERT_NEVER(a_step_needs_slot, clk, arst_n, ctl.step && out_valid_q && !m_tready, "pixel stepped into a full output register")

endmodule
